// ----- src/blrc_pkg.sv -----
// Shared types, constants and helpers of the binary line run-length counter.
// Depends on nothing; blrc_front, blrc_back, blrc_resq and the top level import it.
package blrc_pkg;

	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;

	localparam int GRAY_W = 8;
	localparam int SIZE_W = 9;
	localparam int THR_W  = 8;
	localparam int RUN_W  = 9;
	localparam int LINE_W = 8;

	localparam logic [RUN_W-1:0] RUN_MAX = '1;

	localparam logic [SIZE_W-1:0] WIDTH_RST  = SIZE_W'(256);
	localparam logic [SIZE_W-1:0] HEIGHT_RST = SIZE_W'(256);
	localparam logic [THR_W-1:0]  THR_RST    = THR_W'(128);

	// register indexes on the configuration port
	localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [1:0] REG_THRESHOLD    = 2'd2;

	localparam logic AXIS_ROW = 1'b0;
	localparam logic AXIS_COL = 1'b1;

	localparam int CMDQ_DEPTH = 4;
	localparam int RESQ_DEPTH = 4;

	// classified pixel, front to back
	typedef struct packed {
		logic              set;
		logic              col_end;
		logic              emit_row;
		logic [RUN_W-1:0]  row_len;
		logic [LINE_W-1:0] row_idx;
	} cmd_t;

	localparam int CMD_W = $bits(cmd_t);

	typedef struct packed {
		logic              axis;
		logic [LINE_W-1:0] line_index;
		logic [RUN_W-1:0]  run_length;
		logic              last;
	} res_t;

	function automatic logic [RUN_W-1:0] sat_inc(input logic [RUN_W-1:0] v);
		return (v == RUN_MAX) ? v : v + RUN_W'(1);
	endfunction

endpackage

// ----- src/blrc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module blrc_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- src/blrc_cmdq.sv -----
// Short command queue between the pixel front end and the column back end.
// Generic width; depth comes from the instantiating module.
module blrc_cmdq #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	logic [WIDTH-1:0] buf_q [DEPTH];
	logic [PW-1:0]    wp_q, rp_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = buf_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
			end
			if (do_pop) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + PW'(1);
			end
			cnt_q <= cnt_q + CW'(do_push) - CW'(do_pop);
		end
	end

endmodule

// ----- src/blrc_front.sv -----
// Front end: thresholds pixels, tracks position and the row run, emits commands.
// Depends on blrc_pkg.
module blrc_front import blrc_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
	localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [GRAY_W-1:0] gray,
	input  logic [SIZE_W-1:0] cfg_width,
	input  logic [SIZE_W-1:0] cfg_height,
	input  logic [THR_W-1:0]  cfg_threshold,
	output logic              q_push,
	output logic [XW-1:0]     q_col,
	output cmd_t              q_cmd,
	input  logic              q_full
);

	localparam int WW = ($clog2(MAX_WIDTH + 1) > SIZE_W) ? $clog2(MAX_WIDTH + 1) : SIZE_W;
	localparam int HW = ($clog2(MAX_HEIGHT + 1) > SIZE_W) ? $clog2(MAX_HEIGHT + 1) : SIZE_W;

	logic [XW-1:0]    x_q;
	logic [YW-1:0]    y_q;
	logic [RUN_W-1:0] row_run_q;

	logic [WW-1:0]    w_cfg, w_eff;
	logic [HW-1:0]    h_cfg, h_eff;
	logic             set, row_end, col_end, close_row, accept;
	logic [RUN_W-1:0] row_bumped;

	// clamp sizes: zero acts as one, oversize saturates
	always_comb begin
		w_cfg = WW'(cfg_width);
		h_cfg = HW'(cfg_height);
		if (w_cfg == '0) w_eff = WW'(1);
		else if (w_cfg > WW'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
		else w_eff = w_cfg;
		if (h_cfg == '0) h_eff = HW'(1);
		else if (h_cfg > HW'(MAX_HEIGHT)) h_eff = HW'(MAX_HEIGHT);
		else h_eff = h_cfg;
	end

	assign set        = (gray >= cfg_threshold);
	assign row_end    = (WW'(x_q) >= w_eff - WW'(1));
	assign col_end    = (HW'(y_q) >= h_eff - HW'(1));
	assign close_row  = !set || row_end;
	assign row_bumped = set ? sat_inc(row_run_q) : row_run_q;

	assign full   = q_full;
	assign accept = push && !q_full;
	assign q_push = accept;
	assign q_col  = x_q;

	always_comb begin
		q_cmd.set      = set;
		q_cmd.col_end  = col_end;
		q_cmd.emit_row = close_row && (row_bumped != '0);
		q_cmd.row_len  = row_bumped;
		q_cmd.row_idx  = LINE_W'(y_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q       <= '0;
			y_q       <= '0;
			row_run_q <= '0;
		end else if (accept) begin
			row_run_q <= close_row ? '0 : row_bumped;
			if (row_end) begin
				x_q <= '0;
				y_q <= col_end ? '0 : y_q + YW'(1);
			end else begin
				x_q <= x_q + XW'(1);
			end
		end
	end

endmodule

// ----- src/blrc_back.sv -----
// Back end: read-modify-write of the per-column run counters, builds results.
// Depends on blrc_pkg and blrc_ram.
module blrc_back import blrc_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	output logic          q_pop,
	input  logic [XW-1:0] q_col,
	input  cmd_t          q_cmd,
	input  logic          rq_room,
	output logic [1:0]    rq_n,
	output res_t          rq_d0,
	output res_t          rq_d1
);

	logic                 s1_valid_q;
	cmd_t                 cmd_s1;
	logic [XW-1:0]        col_s1;
	logic                 byp_s1;
	logic [RUN_W-1:0]     byp_val_s1;
	logic [MAX_WIDTH-1:0] vld_q;

	logic [RUN_W-1:0] ram_rdata, cur, bumped, col_new;
	logic             s1_fire, close_col, emit_col;
	res_t             row_res, col_res;

	assign s1_fire = s1_valid_q && rq_room;
	assign q_pop   = !q_empty && (!s1_valid_q || s1_fire);

	blrc_ram #(
		.WIDTH(RUN_W),
		.DEPTH(MAX_WIDTH)
	) u_col_ram (
		.clk  (clk),
		.we   (s1_fire),
		.waddr(col_s1),
		.wdata(col_new),
		.re   (q_pop),
		.raddr(q_col),
		.rdata(ram_rdata)
	);

	// old count: forwarded when the previous pixel wrote this column at read time
	always_comb begin
		if (byp_s1) cur = byp_val_s1;
		else if (vld_q[col_s1]) cur = ram_rdata;
		else cur = '0;
		bumped    = cmd_s1.set ? sat_inc(cur) : cur;
		close_col = !cmd_s1.set || cmd_s1.col_end;
		emit_col  = close_col && (bumped != '0);
		col_new   = close_col ? '0 : bumped;
	end

	always_comb begin
		row_res.axis       = AXIS_ROW;
		row_res.line_index = cmd_s1.row_idx;
		row_res.run_length = cmd_s1.row_len;
		row_res.last       = !emit_col;
		col_res.axis       = AXIS_COL;
		col_res.line_index = LINE_W'(col_s1);
		col_res.run_length = bumped;
		col_res.last       = 1'b1;
		rq_d0 = cmd_s1.emit_row ? row_res : col_res;
		rq_d1 = col_res;
		if (s1_fire) rq_n = 2'(cmd_s1.emit_row) + 2'(emit_col);
		else rq_n = '0;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_s1     <= q_cmd;
			col_s1     <= q_col;
			byp_val_s1 <= col_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			byp_s1     <= 1'b0;
			vld_q      <= '0;
		end else begin
			if (q_pop) begin
				s1_valid_q <= 1'b1;
				byp_s1     <= s1_fire && (col_s1 == q_col);
			end else if (s1_fire) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_fire) begin
				vld_q[col_s1] <= 1'b1;
			end
		end
	end

endmodule

// ----- src/blrc_resq.sv -----
// Result queue: takes up to two results a cycle, hands out one a cycle.
// Depends on blrc_pkg.
module blrc_resq import blrc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] push_n,
	input  res_t       d0,
	input  res_t       d1,
	output logic       room,
	input  logic       pop,
	output logic       empty,
	output res_t       head
);

	localparam int PW = $clog2(RESQ_DEPTH);
	localparam int CW = $clog2(RESQ_DEPTH + 1);

	res_t          buf_q [RESQ_DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic          do_pop;

	assign empty  = (cnt_q == '0);
	assign room   = (cnt_q <= CW'(RESQ_DEPTH - 2));
	assign do_pop = pop && !empty;
	assign head   = buf_q[rp_q];

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			buf_q[wp_q] <= d0;
		end
		if (push_n == 2'd2) begin
			buf_q[wp_q + PW'(1)] <= d1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + PW'(push_n);
			rp_q  <= rp_q + PW'(do_pop);
			cnt_q <= cnt_q + CW'(push_n) - CW'(do_pop);
		end
	end

endmodule

// ----- src/binary_line_run_length_counter_unit.sv -----
// Top level of the binary line run-length counter: config registers and wiring.
// Depends on blrc_pkg, blrc_front, blrc_cmdq, blrc_back, blrc_resq, blrc_ram.
//
//   channel   | handshake             | payload
//   ----------+-----------------------+-------------------------------------------
//   pixel in  | push / full           | gray
//   clue out  | empty / pop           | axis, line_index, run_length, last
//   config    | psel/penable/pwrite   | paddr, pwdata, prdata (pready tied high)
//
// One pixel per clock while no pixel makes two clues and the output does not stall:
// the single column-counter RAM is read on a pop and written as its stage fires,
// with the last write forwarded. Pixels that make two clues are held to one clue
// per cycle at the output. A clue is registered in the command queue, back-end
// stage and result queue. Reset clears position, row run and the per-column valid
// bits at once; the block takes pixels right after reset, no clearing pass. Output
// stalls fill the result queue, then the command queue, then raise full.
module binary_line_run_length_counter_unit import blrc_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic              clk,
	input  logic              arst_n,
	// pixel channel
	input  logic              push,
	output logic              full,
	input  logic [GRAY_W-1:0] gray,
	// clue channel
	output logic              empty,
	input  logic              pop,
	output logic              axis,
	output logic [LINE_W-1:0] line_index,
	output logic [RUN_W-1:0]  run_length,
	output logic              last,
	// configuration port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int XW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int CQW = XW + CMD_W;

	logic [SIZE_W-1:0] width_q, height_q;
	logic [THR_W-1:0]  thr_q;
	logic [1:0]        reg_idx;
	logic              cfg_wr;

	logic           fr_push, cq_full, cq_empty, cq_pop;
	logic [XW-1:0]  fr_col;
	cmd_t           fr_cmd;
	logic [CQW-1:0] cq_wdata, cq_rdata;

	logic [1:0] rq_n;
	logic       rq_room;
	res_t       rq_d0, rq_d1, rq_head;

	// config registers: write in the access phase, no wait states
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			thr_q    <= THR_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_IMAGE_WIDTH:  width_q  <= pwdata[SIZE_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= pwdata[SIZE_W-1:0];
				REG_THRESHOLD:    thr_q    <= pwdata[THR_W-1:0];
				default: ; // drop writes past the last register
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_IMAGE_WIDTH:  prdata = 32'(width_q);
			REG_IMAGE_HEIGHT: prdata = 32'(height_q);
			REG_THRESHOLD:    prdata = 32'(thr_q);
			default:          prdata = '0;
		endcase
	end

	// front: classify the pixel, advance position, close the row run
	blrc_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.gray         (gray),
		.cfg_width    (width_q),
		.cfg_height   (height_q),
		.cfg_threshold(thr_q),
		.q_push       (fr_push),
		.q_col        (fr_col),
		.q_cmd        (fr_cmd),
		.q_full       (cq_full)
	);

	assign cq_wdata = {fr_col, fr_cmd};

	// hold classified pixels so front and back stall independently
	blrc_cmdq #(
		.WIDTH(CQW),
		.DEPTH(CMDQ_DEPTH)
	) u_cmdq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (fr_push),
		.wdata (cq_wdata),
		.full  (cq_full),
		.pop   (cq_pop),
		.rdata (cq_rdata),
		.empty (cq_empty)
	);

	// back: column counter read-modify-write, issue up to two clues per pixel
	blrc_back #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_empty(cq_empty),
		.q_pop  (cq_pop),
		.q_col  (cq_rdata[CMD_W +: XW]),
		.q_cmd  (cmd_t'(cq_rdata[CMD_W-1:0])),
		.rq_room(rq_room),
		.rq_n   (rq_n),
		.rq_d0  (rq_d0),
		.rq_d1  (rq_d1)
	);

	// result queue: oldest clue on the ports while empty is low
	blrc_resq u_resq (
		.clk   (clk),
		.arst_n(arst_n),
		.push_n(rq_n),
		.d0    (rq_d0),
		.d1    (rq_d1),
		.room  (rq_room),
		.pop   (pop),
		.empty (empty),
		.head  (rq_head)
	);

	assign axis       = rq_head.axis;
	assign line_index = rq_head.line_index;
	assign run_length = rq_head.run_length;
	assign last       = rq_head.last;

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// Testbench of binary_line_run_length_counter_unit: drives pixel streams under changing
// frame sizes and thresholds and checks every clue against a scoreboard prediction.
// Depends on blrc_pkg and the RTL of the block.
module tb import blrc_pkg::*; ();

	localparam logic [1:0] REG_SPARE = 2'd3;   // first index past the register list
	localparam int SETTLE_CYCLES   = 8;
	localparam int HOLD_OFF_CYCLES = 200;
	localparam int PIXEL_BUDGET    = 1750;
	localparam int REPORT_LIMIT    = 10;

	typedef enum int {QUIET, SEND_IDLE, RECV_STALL, BOTH_IDLE} pacing_t;
	typedef logic [GRAY_W-1:0] gray_q_t [$];

	// Scoreboard: keeps its own copy of the counters and the registers, turns every
	// accepted pixel into the clues it must produce, and checks clues in order.
	class clue_scoreboard_t;
		logic [SIZE_W-1:0] width_reg;
		logic [SIZE_W-1:0] height_reg;
		logic [THR_W-1:0]  thr_reg;
		logic [RUN_W-1:0]  col_run [DEF_MAX_WIDTH];
		logic [RUN_W-1:0]  row_run;
		logic [LINE_W-1:0] x_pos;
		logic [LINE_W-1:0] y_pos;
		res_t              expected_clues [$];
		int                errors;

		function new();
			width_reg  = WIDTH_RST;
			height_reg = HEIGHT_RST;
			thr_reg    = THR_RST;
			foreach (col_run[i])
				col_run[i] = '0;
			row_run = '0;
			x_pos   = '0;
			y_pos   = '0;
			errors  = 0;
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= REPORT_LIMIT)
				$display("%s", msg);
		endfunction

		// zero means one line, anything past the maximum means the maximum
		function int unsigned size_in_use(logic [SIZE_W-1:0] v, int unsigned top);
			if (v == 0)
				return 1;
			return (v > top) ? top : v;
		endfunction

		function logic [RUN_W-1:0] grown(logic [RUN_W-1:0] v);
			return (v >= RUN_MAX) ? RUN_MAX : v + 1'b1;
		endfunction

		function void note_register(logic [1:0] idx, logic [31:0] value);
			case (idx)
				REG_IMAGE_WIDTH:  width_reg  = value[SIZE_W-1:0];
				REG_IMAGE_HEIGHT: height_reg = value[SIZE_W-1:0];
				REG_THRESHOLD:    thr_reg    = value[THR_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_pixel(logic [GRAY_W-1:0] g);
			int unsigned w, h, col;
			bit          lit, row_end, col_end;
			res_t        clue;
			res_t        made [$];
			w       = size_in_use(width_reg, DEF_MAX_WIDTH);
			h       = size_in_use(height_reg, DEF_MAX_HEIGHT);
			lit     = (g >= thr_reg);
			row_end = (x_pos >= w - 1);
			col_end = (y_pos >= h - 1);
			col     = (x_pos < DEF_MAX_WIDTH) ? x_pos : DEF_MAX_WIDTH - 1;
			if (lit) begin
				row_run      = grown(row_run);
				col_run[col] = grown(col_run[col]);
			end
			// row clue first, then column clue
			if ((!lit || row_end) && row_run != 0) begin
				clue.axis       = AXIS_ROW;
				clue.line_index = y_pos;
				clue.run_length = row_run;
				clue.last       = 1'b0;
				made = {made, clue};
			end
			if (!lit || row_end)
				row_run = '0;
			if ((!lit || col_end) && col_run[col] != 0) begin
				clue.axis       = AXIS_COL;
				clue.line_index = col[LINE_W-1:0];
				clue.run_length = col_run[col];
				clue.last       = 1'b0;
				made = {made, clue};
			end
			if (!lit || col_end)
				col_run[col] = '0;
			if (made.size() > 0)
				made[made.size()-1].last = 1'b1;
			expected_clues = {expected_clues, made};
			// advance the position; a position past a shrunk frame closes it
			if (row_end) begin
				x_pos = '0;
				y_pos = col_end ? '0 : y_pos + 1'b1;
			end else begin
				x_pos = x_pos + 1'b1;
			end
		endfunction

		function void check_clue(res_t got);
			res_t want;
			if (expected_clues.size() == 0) begin
				flag($sformatf("unexpected clue: axis %0d line %0d run %0d last %0d",
					got.axis, got.line_index, got.run_length, got.last));
				return;
			end
			want = expected_clues.pop_front();
			if (got.axis !== want.axis || got.line_index !== want.line_index ||
					got.run_length !== want.run_length || got.last !== want.last)
				flag($sformatf({"clue mismatch: expected axis %0d line %0d run %0d last %0d,",
					" got axis %0d line %0d run %0d last %0d"},
					want.axis, want.line_index, want.run_length, want.last,
					got.axis, got.line_index, got.run_length, got.last));
		endfunction

		function int pending();
			return expected_clues.size();
		endfunction
	endclass

	logic              clk     = 1'b0;
	logic              arst_n  = 1'b0;
	logic              push    = 1'b0;
	logic [GRAY_W-1:0] gray    = '0;
	logic              pop     = 1'b0;
	logic              psel    = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite  = 1'b0;
	logic [3:0]        paddr   = '0;
	logic [31:0]       pwdata  = '0;
	logic              full;
	logic              empty;
	logic              axis;
	logic [LINE_W-1:0] line_index;
	logic [RUN_W-1:0]  run_length;
	logic              last;
	logic [31:0]       prdata;
	logic              pready;

	clue_scoreboard_t board = new();

	int send_pct  = 0;   // chance in a hundred that the sender idles a cycle
	int stall_pct = 0;   // chance in a hundred that the receiver stalls a cycle
	int hold_left = 0;   // cycles the receiver still holds off in one stretch
	bit bright    = 1'b0;

	binary_line_run_length_counter_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.gray       (gray),
		.empty      (empty),
		.pop        (pop),
		.axis       (axis),
		.line_index (line_index),
		.run_length (run_length),
		.last       (last),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Write one register: setup cycle, access cycle, then optionally read it back
	// in a second transaction and compare with the masked value.
	task automatic write_register(input logic [1:0] idx, input logic [31:0] value,
			input bit read_back);
		logic [31:0] mask;
		mask = (idx == REG_THRESHOLD) ? 32'h0FF : 32'h1FF;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		board.note_register(idx, value);
		if (read_back) begin
			// keep psel high: this edge is the setup of the read
			penable <= 1'b0;
			pwrite  <= 1'b0;
			@(posedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
			if (prdata !== (value & mask))
				board.flag($sformatf("register %0d read back: expected %0h, got %0h",
					idx, value & mask, prdata));
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Offer the pixels in order; hold a refused pixel, idle at random otherwise.
	task automatic send_pixels(input gray_q_t pixels);
		int k;
		bit taken;
		k = 0;
		while (k < pixels.size()) begin
			@(posedge clk);
			taken = push && !full;
			if (taken) begin
				board.note_pixel(gray);
				k++;
			end
			if (push && !taken)
				;   // hold the offered pixel until the block takes it
			else if (k < pixels.size() && $urandom_range(0, 99) >= send_pct) begin
				push <= 1'b1;
				gray <= pixels[k];
			end else begin
				push <= 1'b0;
			end
		end
	endtask

	// Wait for every expected clue, then let the pipeline run dry.
	task automatic drain_clues();
		while (board.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic void set_pacing(pacing_t p);
		case (p)
			QUIET:      begin send_pct = 0;  stall_pct = 0;  end
			SEND_IDLE:  begin send_pct = 78; stall_pct = 0;  end
			RECV_STALL: begin send_pct = 0;  stall_pct = 78; end
			default:    begin send_pct = 20; stall_pct = 20; end
		endcase
	endfunction

	function automatic logic [31:0] pick_size();
		case ($urandom_range(0, 11))
			0:       return 32'd0;
			1:       return 32'd1;
			2:       return 32'd256;
			3:       return 32'd511;
			4:       return $urandom_range(257, 510);
			5:       return $urandom_range(9, 40);
			default: return $urandom_range(2, 8);
		endcase
	endfunction

	// Mostly runs of set or clear pixels around the current threshold, some noise.
	function automatic logic [GRAY_W-1:0] pick_gray();
		int t;
		t = board.thr_reg;
		if ($urandom_range(0, 3) == 0)
			bright = !bright;
		if ($urandom_range(0, 9) == 0)
			return GRAY_W'($urandom_range(0, 255));
		if ($urandom_range(0, 9) == 0)
			return GRAY_W'((bright || t == 0) ? t : t - 1);
		if (bright)
			return GRAY_W'($urandom_range(t, 255));
		if (t == 0)
			return GRAY_W'($urandom_range(0, 255));
		return GRAY_W'($urandom_range(0, t - 1));
	endfunction

	// Receiver: check each popped clue, stall at random, honor long hold-offs.
	initial begin
		res_t seen;
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				seen.axis       = axis;
				seen.line_index = line_index;
				seen.run_length = run_length;
				seen.last       = last;
				board.check_clue(seen);
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	initial begin
		gray_q_t pixels;
		int      sent, phase, n;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// 3x2 frame: row run cut by a clear pixel, column runs closed at the bottom,
		// and a last pixel that closes both a row and a column run
		set_pacing(QUIET);
		write_register(REG_IMAGE_WIDTH, 32'd3, 1'b1);
		write_register(REG_IMAGE_HEIGHT, 32'd2, 1'b1);
		write_register(REG_THRESHOLD, 32'd128, 1'b1);
		pixels = '{8'd255, 8'd128, 8'd127, 8'd0, 8'd255, 8'd255};
		send_pixels(pixels);
		drain_clues();

		// zero sizes act as one; threshold zero sets every pixel
		write_register(REG_IMAGE_WIDTH, 32'd0, 1'b1);
		write_register(REG_IMAGE_HEIGHT, 32'd0, 1'b1);
		write_register(REG_THRESHOLD, 32'd0, 1'b1);
		pixels = '{8'd0, 8'd255};
		send_pixels(pixels);
		drain_clues();

		// oversize saturates to the full frame; top threshold; spare index ignored
		write_register(REG_IMAGE_WIDTH, 32'd511, 1'b1);
		write_register(REG_IMAGE_HEIGHT, 32'd511, 1'b1);
		write_register(REG_THRESHOLD, 32'd255, 1'b1);
		write_register(REG_SPARE, 32'hFFFF_FFFF, 1'b0);
		pixels = '{8'd254, 8'd255, 8'd0};
		send_pixels(pixels);
		drain_clues();

		// shrink the width mid-row: the current position then ends the row
		write_register(REG_IMAGE_WIDTH, 32'd8, 1'b1);
		write_register(REG_THRESHOLD, 32'd100, 1'b1);
		pixels = '{8'd200, 8'd99, 8'd100};
		send_pixels(pixels);
		drain_clues();
		write_register(REG_IMAGE_WIDTH, 32'd2, 1'b1);
		pixels = '{8'd200, 8'd200, 8'd50};
		send_pixels(pixels);
		drain_clues();

		sent  = 0;
		phase = 0;
		while (sent < PIXEL_BUDGET) begin
			set_pacing(pacing_t'(phase % 4));
			n = $urandom_range(30, 90);
			case (phase)
				0: begin
					// full-width rows of set pixels: longest row runs, every column index
					write_register(REG_IMAGE_WIDTH, 32'd256, 1'b1);
					write_register(REG_IMAGE_HEIGHT, 32'd3, 1'b1);
					write_register(REG_THRESHOLD, 32'd0, 1'b1);
					n = 260;
				end
				1: begin
					// one pixel per row down a tall frame: every row index
					write_register(REG_IMAGE_WIDTH, 32'd1, 1'b1);
					write_register(REG_IMAGE_HEIGHT, 32'd511, 1'b1);
					write_register(REG_THRESHOLD, $urandom_range(1, 254), 1'b1);
					n = 260;
				end
				default: begin
					if ($urandom_range(0, 2) != 0)
						write_register(REG_IMAGE_WIDTH, pick_size(), 1'b1);
					if ($urandom_range(0, 2) != 0)
						write_register(REG_IMAGE_HEIGHT, pick_size(), 1'b1);
					if ($urandom_range(0, 2) != 0)
						case ($urandom_range(0, 5))
							0:       write_register(REG_THRESHOLD, 32'd0, 1'b1);
							1:       write_register(REG_THRESHOLD, 32'd255, 1'b1);
							2:       write_register(REG_THRESHOLD, 32'd1, 1'b1);
							default: write_register(REG_THRESHOLD, $urandom_range(0, 255), 1'b1);
						endcase
				end
			endcase
			// hold off the receiver while the sender streams, so the block fills
			if (phase == 4)
				hold_left = HOLD_OFF_CYCLES;
			pixels.delete();
			repeat (n) pixels = {pixels, pick_gray()};
			send_pixels(pixels);
			drain_clues();
			sent += n;
			phase++;
		end

		drain_clues();
		if (board.errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("tb: done, errors");
		$finish;
	end

endmodule
